>>> hdl/perfect_hash_lookup_counter_defines.svh
// assertion macros for the perfect hash lookup counter
`ifndef PERFECT_HASH_LOOKUP_COUNTER_DEFINES_SVH
`define PERFECT_HASH_LOOKUP_COUNTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PHL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PHL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PHL_ASSERT_IMP(label, clk, rst_n, a, c)
`define PHL_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/phl_pkg.sv
package phl_pkg;

    typedef enum logic [2:0] {
        FUNC_LOAD_KEY  = 3'd0,
        FUNC_LOAD_SLOT = 3'd1,
        FUNC_LOAD_DISP = 3'd2,
        FUNC_GET       = 3'd3,
        FUNC_CONTAINS  = 3'd4,
        FUNC_SHADOW    = 3'd5,
        FUNC_ADD_HITS  = 3'd6,
        FUNC_READ      = 3'd7
    } func_t;

    localparam logic CFG_BUCKET_COUNT = 1'b0;
    localparam logic CFG_SLOT_COUNT   = 1'b1;

    localparam logic [63:0] MIX_SEED = 64'hD1B54A32D192ED03;
    localparam logic [63:0] MIX_C1   = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] MIX_C2   = 64'hC4CEB9FE1A85EC53;
    localparam logic [63:0] MIX_C3   = 64'hD6E8FEB86659FD93;
    localparam logic [63:0] GOLDEN   = 64'h9E3779B97F4A7C15;
    localparam logic [10:0] SLOT_EMPTY = 11'h7FF;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [10:0] address;
        logic [15:0] write_data;
        logic [30:0] amount;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [9:0]  entry_index;
        logic [30:0] count;
        logic        shadowed;
    } rsp_t;

    // command to the shared multiply unit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] lo;
        logic [63:0] hi;
    } mul_rsp_t;

endpackage

>>> hdl/phl_ram.sv
module phl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/phl_mul.sv
// 64x64 -> 128 multiply from 32x32 partial products, one per cycle
module phl_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  phl_pkg::mul_cmd_t cmd,
    output phl_pkg::mul_rsp_t rsp
);
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg;
    logic [63:0]  a_reg, b_reg;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  prod_reg;
    logic [31:0]  op_a, op_b;
    logic [1:0]   pp_sel;
    logic [127:0] pp_shifted;

    // step 0..3 multiplies, step 1..4 accumulates the previous product
    always_comb
    begin
        pp_sel = step_reg[1:0];
        op_a = pp_sel[0] ? a_reg[63:32] : a_reg[31:0];
        op_b = pp_sel[1] ? b_reg[63:32] : b_reg[31:0];
    end

    always_comb
    begin
        unique case (step_reg)
            3'd2:    pp_shifted = {32'd0, prod_reg, 32'd0};
            3'd3:    pp_shifted = {32'd0, prod_reg, 32'd0};
            3'd4:    pp_shifted = {prod_reg, 64'd0};
            default: pp_shifted = {64'd0, prod_reg};
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd0)
            begin
                acc_next = acc_reg + pp_shifted;
            end
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd4)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= busy_reg && (step_reg == 3'd4);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= cmd.a;
            b_reg <= cmd.b;
        end
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.lo   = acc_reg[63:0];
    assign rsp.hi   = acc_reg[127:64];
endmodule

>>> hdl/perfect_hash_lookup_counter.sv
// perfect hash lookup engine with a hit counter per entry
//
// command channel: drive start with a req beat while busy is low; the beat
// is taken at that edge and busy rises until the result. every command gives
// exactly one result: done pulses for one cycle with rsp valid. the receiver
// cannot stall; a result is lost if not sampled in that cycle.
// config channel: cfg_valid/cfg_ready with cfg_index (0 bucket_count,
// 1 slot_count) and cfg_data; cfg_ready is always high.
// loads and read entry use no multiply; key operations skip the lookup with
// slot_count zero, and otherwise end on an empty or out of range slot, on a
// key mismatch or on a match. the lookup takes eight 64x64 products, each
// built from four 32x32 partial products on the one shared multiplier.
// one command at a time: no new command is taken before the last result.
// reset clears the config registers and starts a clearing pass over the slot
// table and the entry status, max(MAX_SLOTS, MAX_ENTRIES) addresses long,
// during which busy stays high. key and displacement stores are not cleared.
`include "perfect_hash_lookup_counter_defines.svh"
module perfect_hash_lookup_counter #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_SLOTS   = 2048,
    parameter int MAX_BUCKETS = 256,
    parameter int COUNT_BITS  = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  phl_pkg::req_t req,
    output logic          done,
    output phl_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [11:0]   cfg_data
);
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int CLR_N = (MAX_SLOTS > MAX_ENTRIES) ? MAX_SLOTS : MAX_ENTRIES;
    localparam int CW = $clog2(CLR_N) + 1;
    localparam logic [30:0] CMASK = 31'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_READ0, S_READ1, S_MIX0, S_MIX1, S_MIX2, S_MIX3,
        S_MIX4, S_MIX5, S_BKT0, S_BKT1, S_BKT2, S_DISP0, S_DISP1, S_FM0,
        S_FM1, S_FM2, S_SLT0, S_SLT1, S_SLT2, S_ENT0, S_ENT1, S_KEY0,
        S_KEY1, S_FIN
    } state_t;

    state_t        state_reg, state_next;
    phl_pkg::req_t req_reg;
    logic [8:0]    bucket_count_reg;
    logic [11:0]   slot_count_reg;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   base_reg;
    logic [CW-1:0] clr_reg;
    logic          wait_reg;

    // multiply unit
    phl_pkg::mul_cmd_t mcmd;
    phl_pkg::mul_rsp_t mrsp;
    phl_mul u_mul (.clk(clk), .rst_n(rst_n), .cmd(mcmd), .rsp(mrsp));

    // clamped ranges
    logic [31:0] nb, ns;
    always_comb
    begin
        nb = (32'(bucket_count_reg) > 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS)
                                                        : 32'(bucket_count_reg);
        ns = (32'(slot_count_reg) > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS)
                                                    : 32'(slot_count_reg);
    end

    // memories
    logic           key_we;
    logic [EW-1:0]  key_waddr, key_raddr;
    logic [63:0]    keyh_rd, keyl_rd;
    logic           slot_we;
    logic [SW-1:0]  slot_waddr, slot_raddr;
    logic [10:0]    slot_wdata, slot_rd;
    logic           disp_we;
    logic [BW-1:0]  disp_raddr;
    logic [15:0]    disp_rd;
    logic           st_we;
    logic [EW-1:0]  st_addr;
    logic [31:0]    st_wdata, st_rd;

    phl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_keyh (.clk(clk), .we(key_we),
        .waddr(key_waddr), .wdata(req_reg.key_high), .raddr(key_raddr),
        .rdata(keyh_rd));
    phl_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_keyl (.clk(clk), .we(key_we),
        .waddr(key_waddr), .wdata(req_reg.key_low), .raddr(key_raddr),
        .rdata(keyl_rd));
    phl_ram #(.WIDTH(11), .DEPTH(MAX_SLOTS)) u_slot (.clk(clk), .we(slot_we),
        .waddr(slot_waddr), .wdata(slot_wdata), .raddr(slot_raddr),
        .rdata(slot_rd));
    phl_ram #(.WIDTH(16), .DEPTH(MAX_BUCKETS)) u_disp (.clk(clk), .we(disp_we),
        .waddr(req_reg.address[BW-1:0]), .wdata(req_reg.write_data),
        .raddr(disp_raddr), .rdata(disp_rd));
    phl_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_stat (.clk(clk), .we(st_we),
        .waddr(st_addr), .wdata(st_wdata), .raddr(st_addr), .rdata(st_rd));

    logic [EW-1:0] idx_reg;
    logic          addr_ok;
    logic [31:0]   red_hi;
    logic [31:0]   bucket, slot;
    logic [10:0]   ent;
    logic [30:0]   cnt;
    logic          shad;

    always_comb
    begin
        red_hi  = mrsp.hi[31:0];
        bucket  = (red_hi >= 32'(MAX_BUCKETS)) ? 32'(MAX_BUCKETS - 1) : red_hi;
        slot    = (red_hi >= 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS - 1) : red_hi;
        ent     = slot_rd;
        shad    = st_rd[31];
        cnt     = st_rd[30:0] & CMASK;
        addr_ok = 32'(req_reg.address) < 32'(MAX_ENTRIES);
    end

    // memory port control
    always_comb
    begin
        key_we     = (state_reg == S_READ0) && (req_reg.func == phl_pkg::FUNC_LOAD_KEY)
                     && addr_ok;
        key_waddr  = req_reg.address[EW-1:0];
        key_raddr  = idx_reg;
        slot_we    = (state_reg == S_CLEAR) ||
                     ((state_reg == S_READ0) && (req_reg.func == phl_pkg::FUNC_LOAD_SLOT)
                      && (32'(req_reg.address) < 32'(MAX_SLOTS)));
        slot_waddr = (state_reg == S_CLEAR) ? clr_reg[SW-1:0] : req_reg.address[SW-1:0];
        slot_wdata = (state_reg == S_CLEAR) ? phl_pkg::SLOT_EMPTY : req_reg.write_data[10:0];
        slot_raddr = slot[SW-1:0];
        disp_we    = (state_reg == S_READ0) && (req_reg.func == phl_pkg::FUNC_LOAD_DISP)
                     && (32'(req_reg.address) < 32'(MAX_BUCKETS));
        disp_raddr = bucket[BW-1:0];
        st_addr    = (state_reg == S_CLEAR) ? clr_reg[EW-1:0] :
                     (state_reg == S_READ0) ? req_reg.address[EW-1:0] : idx_reg;
        // the clearing pass zeroes the entry status
        st_we      = (state_reg == S_CLEAR);
        st_wdata   = '0;
        if (state_reg == S_FIN && !shad)
        begin
            unique case (req_reg.func)
                phl_pkg::FUNC_GET:
                begin
                    st_we = 1'b1;
                    st_wdata = {1'b0, (st_rd[30:0] + 31'd1) & CMASK};
                end
                phl_pkg::FUNC_SHADOW:
                begin
                    st_we = 1'b1;
                    st_wdata = 32'h8000_0000;
                end
                phl_pkg::FUNC_ADD_HITS:
                begin
                    st_we = 1'b1;
                    st_wdata = {1'b0, (st_rd[30:0] + req_reg.amount) & CMASK};
                end
                default:
                begin
                    st_we = 1'b0;
                end
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        mcmd       = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ0;
                end
            end
            S_READ0:
            begin
                if (req_reg.func == phl_pkg::FUNC_READ)
                begin
                    state_next = S_READ1;
                end
                else if (req_reg.func == phl_pkg::FUNC_LOAD_KEY ||
                         req_reg.func == phl_pkg::FUNC_LOAD_SLOT ||
                         req_reg.func == phl_pkg::FUNC_LOAD_DISP || ns == 32'd0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mcmd = '{1'b1, req_reg.key_high ^ phl_pkg::MIX_SEED, phl_pkg::MIX_C1};
                    state_next = S_MIX0;
                end
            end
            S_READ1:
            begin
                state_next = S_IDLE;
            end
            S_MIX0:
            begin
                if (mrsp.done)
                begin
                    x_next = mrsp.lo ^ (mrsp.lo >> 32);
                    x_next = x_next + req_reg.key_low;
                    mcmd = '{1'b1, x_next, phl_pkg::MIX_C2};
                    state_next = S_MIX1;
                end
            end
            S_MIX1:
            begin
                if (mrsp.done)
                begin
                    x_next = mrsp.lo ^ (mrsp.lo >> 29);
                    mcmd = '{1'b1, x_next, phl_pkg::MIX_C3};
                    state_next = S_MIX2;
                end
            end
            S_MIX2:
            begin
                if (mrsp.done)
                begin
                    x_next = mrsp.lo ^ (mrsp.lo >> 32);
                    mcmd = '{1'b1, x_next, {32'd0, nb}};
                    state_next = S_BKT0;
                end
            end
            S_BKT0:
            begin
                if (mrsp.done)
                begin
                    state_next = S_DISP0;
                end
            end
            S_DISP0:
            begin
                state_next = S_DISP1;
            end
            S_DISP1:
            begin
                mcmd = '{1'b1, {48'd0, disp_rd} + 64'd1, phl_pkg::GOLDEN};
                state_next = S_FM0;
            end
            S_FM0:
            begin
                if (mrsp.done)
                begin
                    x_next = base_reg ^ mrsp.lo;
                    x_next = x_next ^ (x_next >> 33);
                    mcmd = '{1'b1, x_next, phl_pkg::MIX_C1};
                    state_next = S_FM1;
                end
            end
            S_FM1:
            begin
                if (mrsp.done)
                begin
                    x_next = mrsp.lo ^ (mrsp.lo >> 33);
                    mcmd = '{1'b1, x_next, phl_pkg::MIX_C2};
                    state_next = S_FM2;
                end
            end
            S_FM2:
            begin
                if (mrsp.done)
                begin
                    x_next = mrsp.lo ^ (mrsp.lo >> 33);
                    mcmd = '{1'b1, x_next, {32'd0, ns}};
                    state_next = S_SLT0;
                end
            end
            S_SLT0:
            begin
                if (mrsp.done)
                begin
                    state_next = S_SLT1;
                end
            end
            S_SLT1:
            begin
                state_next = S_SLT2;
            end
            S_SLT2:
            begin
                if (ent == phl_pkg::SLOT_EMPTY || 32'(ent) >= 32'(MAX_ENTRIES))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KEY0;
                end
            end
            S_KEY0:
            begin
                state_next = S_KEY1;
            end
            S_KEY1:
            begin
                if (keyh_rd != req_reg.key_high || keyl_rd != req_reg.key_low)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result beat
    phl_pkg::rsp_t rsp_next;
    logic          done_next;
    always_comb
    begin
        rsp_next  = '0;
        done_next = 1'b0;
        unique case (state_reg)
            S_READ0:
            begin
                done_next = (state_next == S_IDLE);
            end
            S_READ1:
            begin
                done_next = 1'b1;
                if (addr_ok)
                begin
                    rsp_next.hit = 1'b1;
                    rsp_next.entry_index = 10'(req_reg.address);
                    rsp_next.shadowed = shad;
                    rsp_next.count = shad ? 31'd0 : cnt;
                end
            end
            S_SLT2:
            begin
                done_next = (state_next == S_IDLE);
            end
            S_KEY1:
            begin
                done_next = (state_next == S_IDLE);
            end
            S_FIN:
            begin
                done_next = 1'b1;
                rsp_next.entry_index = 10'(idx_reg);
                rsp_next.hit = !shad;
                if (!shad && req_reg.func == phl_pkg::FUNC_SHADOW)
                begin
                    rsp_next.count = cnt;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            bucket_count_reg <= '0;
            slot_count_reg   <= '0;
            done             <= 1'b0;
            rsp              <= '0;
            wait_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= done_next;
            rsp       <= rsp_next;
            wait_reg  <= (state_next != S_IDLE);
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cfg_valid)
            begin
                if (cfg_index == phl_pkg::CFG_BUCKET_COUNT)
                begin
                    bucket_count_reg <= cfg_data[8:0];
                end
                else
                begin
                    slot_count_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req;
        end
        x_reg <= x_next;
        if (state_reg == S_MIX2 && mrsp.done)
        begin
            base_reg <= x_next;
        end
        if (state_reg == S_SLT2)
        begin
            idx_reg <= ent[EW-1:0];
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    `PHL_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `PHL_ASSERT_IMP(a_done_idle, clk, rst_n, done, !wait_reg || state_reg == S_IDLE)
    `PHL_ASSERT_IMP(a_st_write_fin, clk, rst_n, st_we, state_reg == S_FIN || state_reg == S_CLEAR)
    `PHL_ASSERT_IMP(a_rsp_shadow, clk, rst_n, done && rsp.shadowed, rsp.count == 31'd0)
endmodule

>>> dv/tb_perfect_hash_lookup_counter.sv
module tb_perfect_hash_lookup_counter;

    localparam int NUM_ENTRIES = 1024;
    localparam int NUM_SLOTS   = 2048;
    localparam int NUM_BUCKETS = 256;
    localparam int IDLE_LIMIT  = 30000;

    // reference of the lookup engine: tables, counters and pending results
    class hash_table_scoreboard;
        logic [63:0] key_hi_mem [NUM_ENTRIES];
        logic [63:0] key_lo_mem [NUM_ENTRIES];
        logic [10:0] slot_mem [NUM_SLOTS];
        logic [15:0] disp_mem [NUM_BUCKETS];
        logic [31:0] status_mem [NUM_ENTRIES];
        logic [8:0]  buckets;
        logic [11:0] slots;
        phl_pkg::rsp_t pending [$];
        int          fails;

        function void clear();
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                key_hi_mem[i] = '0;
                key_lo_mem[i] = '0;
                status_mem[i] = '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_mem[i] = phl_pkg::SLOT_EMPTY;
            for (int i = 0; i < NUM_BUCKETS; i++)
                disp_mem[i] = '0;
            buckets = '0;
            slots   = '0;
            fails   = 0;
        endfunction

        function void set_reg(logic idx, logic [11:0] val);
            if (idx == phl_pkg::CFG_BUCKET_COUNT)
                buckets = val[8:0];
            else
                slots = val;
        endfunction

        // high word of hash times range
        function logic [31:0] scale(logic [63:0] h, logic [31:0] range);
            logic [95:0] p;
            p = {32'b0, h} * {64'b0, range};
            return p[95:64];
        endfunction

        function logic [63:0] finalize(logic [63:0] x);
            x = x ^ (x >> 33);
            x = x * phl_pkg::MIX_C1;
            x = x ^ (x >> 33);
            x = x * phl_pkg::MIX_C2;
            x = x ^ (x >> 33);
            return x;
        endfunction

        function logic [63:0] base_hash(logic [63:0] h0, logic [63:0] h1);
            logic [63:0] a;
            a = h0 ^ phl_pkg::MIX_SEED;
            a = a * phl_pkg::MIX_C1;
            a = a ^ (a >> 32);
            a = a + h1;
            a = a * phl_pkg::MIX_C2;
            a = a ^ (a >> 29);
            a = a * phl_pkg::MIX_C3;
            a = a ^ (a >> 32);
            return a;
        endfunction

        // slot the key lands in, or -1 with no slots in use
        function int slot_of(logic [63:0] h0, logic [63:0] h1);
            int unsigned nb, ns, b, s;
            logic [63:0] base, sh;
            nb = (buckets > NUM_BUCKETS) ? NUM_BUCKETS : buckets;
            ns = (slots > NUM_SLOTS) ? NUM_SLOTS : slots;
            if (ns == 0)
                return -1;
            base = base_hash(h0, h1);
            b = scale(base, nb);
            if (b >= NUM_BUCKETS)
                b = NUM_BUCKETS - 1;
            sh = finalize(base ^ (({48'b0, disp_mem[b]} + 64'd1) * phl_pkg::GOLDEN));
            s = scale(sh, ns);
            if (s >= NUM_SLOTS)
                s = NUM_SLOTS - 1;
            return s;
        endfunction

        function bit find(logic [63:0] h0, logic [63:0] h1, output int unsigned idx);
            int s;
            int unsigned e;
            idx = 0;
            s = slot_of(h0, h1);
            if (s < 0)
                return 0;
            e = slot_mem[s];
            if (e >= NUM_ENTRIES)
                return 0;
            if (key_hi_mem[e] != h0 || key_lo_mem[e] != h1)
                return 0;
            idx = e;
            return 1;
        endfunction

        // accepted command beat: update tables and queue the expected result
        function void note(phl_pkg::req_t r);
            phl_pkg::rsp_t x;
            int unsigned   idx;
            logic [31:0]   st;
            x = '0;
            case (phl_pkg::func_t'(r.func))
                phl_pkg::FUNC_LOAD_KEY:
                    if (r.address < NUM_ENTRIES)
                    begin
                        key_hi_mem[r.address] = r.key_high;
                        key_lo_mem[r.address] = r.key_low;
                    end
                phl_pkg::FUNC_LOAD_SLOT:
                    slot_mem[r.address] = r.write_data[10:0];
                phl_pkg::FUNC_LOAD_DISP:
                    if (r.address < NUM_BUCKETS)
                        disp_mem[r.address] = r.write_data;
                phl_pkg::FUNC_READ:
                    if (r.address < NUM_ENTRIES)
                    begin
                        st = status_mem[r.address];
                        x.hit = 1'b1;
                        x.entry_index = r.address[9:0];
                        x.shadowed = st[31];
                        x.count = st[31] ? '0 : st[30:0];
                    end
                default:
                    if (find(r.key_high, r.key_low, idx))
                    begin
                        x.entry_index = idx[9:0];
                        st = status_mem[idx];
                        if (!st[31])
                        begin
                            x.hit = 1'b1;
                            case (phl_pkg::func_t'(r.func))
                                phl_pkg::FUNC_GET:
                                    status_mem[idx] = {1'b0, st[30:0] + 31'd1};
                                phl_pkg::FUNC_SHADOW:
                                begin
                                    x.count = st[30:0];
                                    status_mem[idx] = 32'h8000_0000;
                                end
                                phl_pkg::FUNC_ADD_HITS:
                                    status_mem[idx] = {1'b0, st[30:0] + r.amount};
                                default: ;
                            endcase
                        end
                    end
            endcase
            pending = {pending, x};
        endfunction

        function void check(phl_pkg::rsp_t got);
            phl_pkg::rsp_t x;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                fails++;
                return;
            end
            x = pending.pop_front();
            if (got.hit !== x.hit)
            begin
                $error("hit: expected %0h actual %0h", x.hit, got.hit);
                fails++;
            end
            if (got.entry_index !== x.entry_index)
            begin
                $error("entry_index: expected %0d actual %0d", x.entry_index, got.entry_index);
                fails++;
            end
            if (got.count !== x.count)
            begin
                $error("count: expected %0d actual %0d", x.count, got.count);
                fails++;
            end
            if (got.shadowed !== x.shadowed)
            begin
                $error("shadowed: expected %0h actual %0h", x.shadowed, got.shadowed);
                fails++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    phl_pkg::req_t req;
    logic          done;
    phl_pkg::rsp_t rsp;
    logic          cfg_valid;
    logic          cfg_ready;
    logic          cfg_index;
    logic [11:0]   cfg_data;

    hash_table_scoreboard sb;
    logic [63:0] inst_hi [$];
    logic [63:0] inst_lo [$];
    bit          key_loaded [NUM_ENTRIES];
    int          next_entry;
    int          burst_left;
    int          idle_cycles;

    perfect_hash_lookup_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(rsp);
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one command beat, held until taken
    task automatic send(phl_pkg::req_t r);
        req   <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        sb.note(r);
    endtask

    // bursts of back-to-back commands with random gaps in between
    task automatic pace();
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
        end
        burst_left--;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function phl_pkg::req_t mk(phl_pkg::func_t f, logic [63:0] kh, logic [63:0] kl,
                               logic [10:0] a, logic [15:0] wd, logic [30:0] amt);
        phl_pkg::req_t r;
        r.func = f;
        r.key_high = kh;
        r.key_low = kl;
        r.address = a;
        r.write_data = wd;
        r.amount = amt;
        return r;
    endfunction

    // point the slot the key hashes to at its entry
    task automatic place(int e, logic [63:0] kh, logic [63:0] kl);
        int s;
        s = sb.slot_of(kh, kl);
        if (s >= 0)
            send(mk(phl_pkg::FUNC_LOAD_SLOT, rand64(), rand64(), s[10:0],
                    {5'($urandom_range(0, 31)), e[10:0]}, 31'($urandom)));
    endtask

    // fresh entry: load its key then its slot
    task automatic install(logic [63:0] kh, logic [63:0] kl);
        int e;
        e = next_entry;
        next_entry = (next_entry + 1) % NUM_ENTRIES;
        send(mk(phl_pkg::FUNC_LOAD_KEY, kh, kl, e[10:0], 16'($urandom), 31'($urandom)));
        key_loaded[e] = 1'b1;
        place(e, kh, kl);
        inst_hi = {inst_hi, kh};
        inst_lo = {inst_lo, kl};
    endtask

    function logic [30:0] rand_amount();
        case ($urandom_range(0, 3))
            0: return 31'h7FFF_FFFF;
            1: return 31'($urandom_range(0, 20));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int unsigned sel, k, v;
        logic [63:0] kh, kl;
        phl_pkg::func_t f;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, inst_hi.size() - 1);
        kh = inst_hi[k];
        kl = inst_lo[k];
        if (sel < 8)
        begin
            f = phl_pkg::FUNC_SHADOW;
        end
        else
        begin
            f = phl_pkg::func_t'(3'(phl_pkg::FUNC_GET + $urandom_range(0, 3)));
            if (f == phl_pkg::FUNC_SHADOW)
                f = phl_pkg::FUNC_GET;
        end
        if (sel < 65)
            send(mk(f, kh, kl, 11'($urandom), 16'($urandom), rand_amount()));
        else if (sel < 73)
            send(mk(phl_pkg::func_t'(3'(phl_pkg::FUNC_GET + $urandom_range(0, 3))),
                    rand64(), rand64(), 11'($urandom), 16'($urandom), rand_amount()));
        else if (sel < 83)
            send(mk(phl_pkg::FUNC_READ, rand64(), rand64(), 11'($urandom), 16'($urandom),
                    31'($urandom)));
        else if (sel < 90)
            install(rand64(), rand64());
        else if (sel < 95)
        begin
            // slot entry: loaded entry, empty marker or out of range index
            case ($urandom_range(0, 2))
                0: v = phl_pkg::SLOT_EMPTY;
                1: v = $urandom_range(NUM_ENTRIES, NUM_SLOTS - 2);
                default:
                begin
                    v = $urandom_range(0, NUM_ENTRIES - 1);
                    if (!key_loaded[v])
                        v = phl_pkg::SLOT_EMPTY;
                end
            endcase
            send(mk(phl_pkg::FUNC_LOAD_SLOT, rand64(), rand64(), 11'($urandom),
                    {5'($urandom_range(0, 31)), v[10:0]}, 31'($urandom)));
        end
        else
        begin
            // key load aimed past the table is ignored
            send(mk(phl_pkg::FUNC_LOAD_KEY, rand64(), rand64(),
                    11'($urandom_range(NUM_ENTRIES, NUM_SLOTS - 1)), 16'($urandom),
                    31'($urandom)));
        end
    endtask

    task automatic run_phase(logic [8:0] nb, logic [11:0] ns, int n);
        drain();
        write_reg(phl_pkg::CFG_BUCKET_COUNT, {3'b0, nb});
        write_reg(phl_pkg::CFG_SLOT_COUNT, ns);
        burst_left = 0;
        // fresh keys placed under the new sizes
        for (int i = 0; i < 8; i++)
            install(rand64(), rand64());
        for (int i = 0; i < n; i++)
        begin
            pace();
            random_item();
        end
    endtask

    initial
    begin
        logic [63:0] kh, kl;
        sb = new();
        sb.clear();
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = phl_pkg::CFG_BUCKET_COUNT;
        cfg_data  = '0;
        next_entry = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads before anything is loaded, and ignored loads past the tables
        send(mk(phl_pkg::FUNC_READ, '0, '0, 11'd0, '0, '0));
        send(mk(phl_pkg::FUNC_READ, '1, '1, 11'd2047, '1, '1));
        send(mk(phl_pkg::FUNC_LOAD_KEY, '1, '1, 11'd2047, '1, '1));
        send(mk(phl_pkg::FUNC_LOAD_DISP, '0, '0, 11'd2047, 16'hFFFF, '0));
        send(mk(phl_pkg::FUNC_CONTAINS, rand64(), rand64(), '0, '0, '0));

        // every displacement gets a value before any lookup can read it
        for (int b = 0; b < NUM_BUCKETS; b++)
            send(mk(phl_pkg::FUNC_LOAD_DISP, rand64(), rand64(), b[10:0],
                    (b == 0) ? 16'hFFFF : (b == 1) ? 16'h0000 : 16'($urandom),
                    31'($urandom)));

        drain();
        write_reg(phl_pkg::CFG_BUCKET_COUNT, 12'd16);
        write_reg(phl_pkg::CFG_SLOT_COUNT, 12'd64);

        // extreme keys and the counter cases on one entry
        install('0, '0);
        install('1, '1);
        kh = rand64();
        kl = rand64();
        install(kh, kl);
        send(mk(phl_pkg::FUNC_GET, '0, '0, '0, '0, '0));
        send(mk(phl_pkg::FUNC_CONTAINS, '1, '1, '1, '1, '1));
        send(mk(phl_pkg::FUNC_GET, kh, kl, '0, '0, '0));
        send(mk(phl_pkg::FUNC_ADD_HITS, kh, kl, '0, '0, 31'h7FFF_FFFF));
        send(mk(phl_pkg::FUNC_GET, kh, kl, '0, '0, '0));
        send(mk(phl_pkg::FUNC_ADD_HITS, kh, kl, '0, '0, 31'h7FFF_FFFE));
        send(mk(phl_pkg::FUNC_READ, '0, '0, 11'd2, '0, '0));
        send(mk(phl_pkg::FUNC_SHADOW, kh, kl, '0, '0, '0));
        send(mk(phl_pkg::FUNC_SHADOW, kh, kl, '0, '0, '0));
        send(mk(phl_pkg::FUNC_GET, kh, kl, '0, '0, '0));
        send(mk(phl_pkg::FUNC_READ, '0, '0, 11'd2, '0, '0));
        send(mk(phl_pkg::FUNC_READ, '0, '0, 11'd1023, '0, '0));
        send(mk(phl_pkg::FUNC_READ, '0, '0, 11'd1024, '0, '0));
        // out of range and empty slot entries answer absent
        send(mk(phl_pkg::FUNC_LOAD_SLOT, '0, '0, 11'(sb.slot_of('1, '1)), 16'hFDDC, '0));
        send(mk(phl_pkg::FUNC_CONTAINS, '1, '1, '0, '0, '0));
        send(mk(phl_pkg::FUNC_LOAD_SLOT, '0, '0, 11'(sb.slot_of('0, '0)), 16'h07FF, '0));
        send(mk(phl_pkg::FUNC_CONTAINS, '0, '0, '0, '0, '0));

        run_phase(9'd16, 12'd64, 30);
        run_phase(9'd0, 12'd1, 25);
        run_phase(9'd511, 12'd4095, 30);
        run_phase(9'd256, 12'd2048, 30);
        run_phase(9'd7, 12'd0, 20);
        run_phase(9'd200, 12'd1500, 30);

        drain();
        repeat (70) @(posedge clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
